[rtl/rwt_pkg.sv]
// Shared types, register codes and constants for the reflective wheel tachometer.
package rwt_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int RAW_BITS   = 10;
	localparam int TS_BITS    = 64;
	localparam int CMD_BITS   = 8;
	localparam int MINC_BITS  = 10;
	localparam int MINH_BITS  = 9;
	localparam int PER_BITS   = 24;
	localparam int TOUT_BITS  = 32;
	localparam int RPM_BITS   = 16;
	localparam int SRPM_BITS  = 17;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 32;
	localparam int S_TDATA_BITS  = 88;
	localparam int M_TDATA_BITS  = 64;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_CONTRAST = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_HYST     = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_PERIOD   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PERIOD   = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT      = 3'd4;

	// register reset values
	localparam logic [MINC_BITS-1:0] RST_MIN_CONTRAST = 10'd80;
	localparam logic [MINH_BITS-1:0] RST_MIN_HYST     = 9'd16;
	localparam logic [PER_BITS-1:0]  RST_MIN_PERIOD   = 24'd100000;
	localparam logic [PER_BITS-1:0]  RST_MAX_PERIOD   = 24'd5000000;
	localparam logic [TOUT_BITS-1:0] RST_TIMEOUT      = 32'd6000000;

	// 60e6 us per minute times 64 for Q10.6
	localparam logic [31:0] RPM_NUMERATOR = 32'd3840000000;

	// item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_DRIVE  = 1'b1;

	// direction codes, two's complement in two bits
	localparam logic [1:0] DIR_NONE = 2'b00;
	localparam logic [1:0] DIR_FWD  = 2'b01;
	localparam logic [1:0] DIR_REV  = 2'b11;

	typedef struct packed {
		logic [MINC_BITS-1:0] min_contrast;
		logic [MINH_BITS-1:0] min_hyst;
		logic [PER_BITS-1:0]  min_period;
		logic [PER_BITS-1:0]  max_period;
		logic [TOUT_BITS-1:0] timeout;
	} cfg_t;

	typedef struct packed {
		logic                kind;
		logic [1:0]          cmd_dir;   // DIR_NONE keeps the direction
		logic [RAW_BITS-1:0] raw;
		logic [TS_BITS-1:0]  ts;
	} item_t;

endpackage

[rtl/reflective_wheel_tachometer_unit.sv]
// Top level of the reflective wheel tachometer: config bank, front, queue, engine.
//
// Reflective wheel tachometer. Each input beat is either a sensor sample with
// a microsecond timestamp (tuser = 0) or a drive command whose sign sets the
// reported direction (tuser = 1); every beat yields exactly one result beat.
// Samples update a running min/max; when the spread reaches min_contrast a
// hysteresis comparator around the midpoint (half-band = contrast/8, floored
// at min_hysteresis) detects rising edges, and an edge-to-edge period within
// [min_period_us, max_period_us] gives rpm = 3840000000/period in Q10.6,
// saturating at 65535. An edge age above timeout_us drops the speed.
// A drive command passes the engine's idle and emit states, a sample also
// the threshold and level states, and a sample that completes an accepted
// period also runs the bit-serial rpm divider (one quotient bit per cycle).
// The engine works on one item at a time; a two-entry queue in front of it
// keeps accepting beats, and the output register lets a finished result wait
// for m_tready without blocking the next item's processing. Configuration
// writes (cfg_ready is always high) must be made while the block is idle.
module reflective_wheel_tachometer_unit #(
	parameter int SAMPLE_BITS = rwt_pkg::SAMPLE_BITS_DEF,
	parameter int QUEUE_DEPTH = rwt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rwt_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [rwt_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// input beats
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// raw_sample[9:0], timestamp_us[73:10], drive_command[81:74], zero fill
	input  logic [rwt_pkg::S_TDATA_BITS-1:0]  s_tdata,
	// func[0]
	input  logic [0:0]                        s_tuser,
	// result beats
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// speed_rpm[15:0], signed_speed_rpm[32:16], period_out_us[56:33],
	// level_is_high[57], zero fill
	output logic [rwt_pkg::M_TDATA_BITS-1:0]  m_tdata,
	// speed_valid[0]
	output logic [0:0]                        m_tuser
);
	localparam int ITEM_BITS = $bits(rwt_pkg::item_t);

	rwt_pkg::cfg_t  cfg_q;
	rwt_pkg::item_t front_item, back_item;
	logic           q_push, q_pop, q_empty, q_full;
	logic [ITEM_BITS-1:0] q_rd;

	// configuration bank; writes past the last register are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_contrast <= rwt_pkg::RST_MIN_CONTRAST;
			cfg_q.min_hyst     <= rwt_pkg::RST_MIN_HYST;
			cfg_q.min_period   <= rwt_pkg::RST_MIN_PERIOD;
			cfg_q.max_period   <= rwt_pkg::RST_MAX_PERIOD;
			cfg_q.timeout      <= rwt_pkg::RST_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rwt_pkg::REG_MIN_CONTRAST: cfg_q.min_contrast <= cfg_data[9:0];
				rwt_pkg::REG_MIN_HYST:     cfg_q.min_hyst     <= cfg_data[8:0];
				rwt_pkg::REG_MIN_PERIOD:   cfg_q.min_period   <= cfg_data[23:0];
				rwt_pkg::REG_MAX_PERIOD:   cfg_q.max_period   <= cfg_data[23:0];
				rwt_pkg::REG_TIMEOUT:      cfg_q.timeout      <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept and classify
	rwt_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (front_item)
	);

	// decoupling queue
	rwt_fifo #(
		.WIDTH (ITEM_BITS),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (front_item),
		.pop     (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty),
		.full    (q_full)
	);

	assign back_item = rwt_pkg::item_t'(q_rd);

	// back: per-sample engine with rpm divider and output register
	rwt_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_item   (back_item),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

[rtl/rwt_fifo.sv]
// Short register queue between the classifier and the sample engine.
module rwt_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [NW-1:0]    count_q;
	logic             do_push, do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == NW'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

[rtl/rwt_front.sv]
// Input side: takes stream beats and classifies them into queue items.
module rwt_front (
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [rwt_pkg::S_TDATA_BITS-1:0] s_tdata,
	input  logic [0:0]                      s_tuser,
	input  logic                            q_full,
	output logic                            q_push,
	output rwt_pkg::item_t                  q_item
);
	logic [rwt_pkg::CMD_BITS-1:0] cmd;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;
	assign cmd      = s_tdata[81:74];

	always_comb begin
		q_item.kind = s_tuser[0] ? rwt_pkg::KIND_DRIVE : rwt_pkg::KIND_SAMPLE;
		q_item.raw  = s_tdata[9:0];
		q_item.ts   = s_tdata[73:10];
		// sign of the command picks the direction, zero keeps it
		if (cmd == '0)
			q_item.cmd_dir = rwt_pkg::DIR_NONE;
		else if (cmd[rwt_pkg::CMD_BITS-1])
			q_item.cmd_dir = rwt_pkg::DIR_REV;
		else
			q_item.cmd_dir = rwt_pkg::DIR_FWD;
	end

endmodule

[rtl/rwt_back.sv]
// Sample engine: min/max tracking, hysteresis comparator, edge timing, rpm divider.
module rwt_back #(
	parameter int SAMPLE_BITS = rwt_pkg::SAMPLE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  rwt_pkg::cfg_t                    cfg,
	input  rwt_pkg::item_t                   q_item,
	input  logic                             q_empty,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rwt_pkg::M_TDATA_BITS-1:0] m_tdata,
	output logic [0:0]                       m_tuser
);
	localparam int SW = SAMPLE_BITS;
	localparam int CW = ((SW > rwt_pkg::MINC_BITS) ? SW : rwt_pkg::MINC_BITS) + 1;
	localparam logic [SW-1:0] SMAX = {SW{1'b1}};
	localparam logic [rwt_pkg::RAW_BITS-1:0] RAW_MASK = (SW >= rwt_pkg::RAW_BITS) ?
		{rwt_pkg::RAW_BITS{1'b1}} : rwt_pkg::RAW_BITS'((1 << SW) - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_THR  = 3'd1;
	localparam logic [2:0] ST_LVL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]    state_q;
	logic [SW-1:0] min_q, max_q;
	logic          level_q, lready_q, valid_q, edge_q;
	logic [63:0]   last_edge_q;
	logic [23:0]   period_q;
	logic [15:0]   rpm_q;
	logic [1:0]    dir_q;
	logic [4:0]    cnt_q;
	logic          m_valid_q;

	// payload registers
	logic [SW-1:0] samp_q, mid_q, lower_q, upper_q;
	logic [63:0]   ts_q, diff_q;
	logic          ok_q, in_range_q, tout_q;
	logic [23:0]   rem_q;
	logic [31:0]   num_q;
	logic [rwt_pkg::M_TDATA_BITS-1:0] m_tdata_q;
	logic          m_tuser_q;

	logic [SW-1:0] samp, new_min, new_max, contrast, mid_c, lower_c, upper_c;
	logic [CW-1:0] hyst_c, sum_c, mid_w;
	logic          ok_c, in_range_c, tout_c;
	logic [24:0]   trial;
	logic          trial_ge;
	logic [15:0]   rpm_out;
	logic [16:0]   srpm_out;
	logic          out_free, rise, fall, accept_per;

	assign samp    = SW'(q_item.raw & RAW_MASK);
	assign new_min = (samp < min_q) ? samp : min_q;
	assign new_max = (samp > max_q) ? samp : max_q;
	assign q_pop   = (state_q == ST_IDLE) && !q_empty;

	// threshold arithmetic on the updated extremes
	always_comb begin
		contrast = (max_q >= min_q) ? (max_q - min_q) : '0;
		ok_c     = CW'(contrast) >= CW'(cfg.min_contrast);
		mid_c    = min_q + (contrast >> 1);
		mid_w    = CW'(mid_c);
		hyst_c   = CW'(contrast >> 3);
		if (hyst_c < CW'(cfg.min_hyst))
			hyst_c = CW'(cfg.min_hyst);
		lower_c  = (mid_w > hyst_c) ? SW'(mid_w - hyst_c) : '0;
		sum_c    = mid_w + hyst_c;
		upper_c  = (sum_c < CW'(SMAX)) ? SW'(sum_c) : SMAX;
		in_range_c = (diff_q >= 64'(cfg.min_period)) && (diff_q <= 64'(cfg.max_period));
		tout_c     = edge_q && (diff_q > 64'(cfg.timeout));
	end

	assign rise       = lready_q && !level_q && (samp_q >= upper_q);
	assign fall       = lready_q && level_q && (samp_q <= lower_q);
	assign accept_per = rise && edge_q && in_range_q;

	// restoring divider step
	assign trial    = {rem_q, num_q[31]};
	assign trial_ge = trial >= {1'b0, period_q};

	assign out_free = !m_valid_q || m_tready;
	assign rpm_out  = valid_q ? rpm_q : '0;
	always_comb begin
		case (dir_q)
			rwt_pkg::DIR_FWD: srpm_out = {1'b0, rpm_out};
			rwt_pkg::DIR_REV: srpm_out = 17'(-{1'b0, rpm_out});
			default:          srpm_out = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			min_q       <= SMAX;
			max_q       <= '0;
			level_q     <= 1'b0;
			lready_q    <= 1'b0;
			valid_q     <= 1'b0;
			edge_q      <= 1'b0;
			last_edge_q <= '0;
			period_q    <= '0;
			rpm_q       <= '0;
			dir_q       <= rwt_pkg::DIR_NONE;
			cnt_q       <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			// output register: load a finished result, else drop a taken beat
			if (state_q == ST_EMIT && out_free)
				m_valid_q <= 1'b1;
			else if (m_tready)
				m_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_item.kind == rwt_pkg::KIND_DRIVE) begin
							if (q_item.cmd_dir != rwt_pkg::DIR_NONE)
								dir_q <= q_item.cmd_dir;
							state_q <= ST_EMIT;
						end else begin
							min_q   <= new_min;
							max_q   <= new_max;
							state_q <= ST_THR;
						end
					end
				end
				ST_THR: state_q <= ST_LVL;
				ST_LVL: begin
					state_q <= ST_EMIT;
					if (!ok_q) begin
						valid_q <= 1'b0;
					end else if (!lready_q) begin
						level_q  <= samp_q >= mid_q;
						lready_q <= 1'b1;
						if (tout_q) begin
							valid_q <= 1'b0;
							rpm_q   <= '0;
						end
					end else if (rise) begin
						level_q     <= 1'b1;
						last_edge_q <= ts_q;
						edge_q      <= 1'b1;
						if (accept_per) begin
							period_q <= diff_q[23:0];
							cnt_q    <= 5'd31;
							state_q  <= ST_DIV;
						end
					end else begin
						if (fall)
							level_q <= 1'b0;
						if (tout_q) begin
							valid_q <= 1'b0;
							rpm_q   <= '0;
						end
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						// num_q holds the quotient after this step
						rpm_q   <= (num_q[30:15] != '0) ? 16'hFFFF : {num_q[14:0], trial_ge};
						valid_q <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			samp_q <= samp;
			ts_q   <= q_item.ts;
			diff_q <= q_item.ts - last_edge_q;
		end
		if (state_q == ST_THR) begin
			ok_q       <= ok_c;
			mid_q      <= mid_c;
			lower_q    <= lower_c;
			upper_q    <= upper_c;
			in_range_q <= in_range_c;
			tout_q     <= tout_c;
		end
		if (state_q == ST_LVL) begin
			rem_q <= '0;
			num_q <= rwt_pkg::RPM_NUMERATOR;
		end else if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? 24'(trial - {1'b0, period_q}) : trial[23:0];
			num_q <= {num_q[30:0], trial_ge};
		end
		if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= {6'b0, level_q, period_q, srpm_out, rpm_out};
			m_tuser_q <= valid_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[verif/tb_reflective_wheel_tachometer_unit.sv]
// Self-checking testbench for the reflective wheel tachometer unit.
module tb_reflective_wheel_tachometer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAW_W  = rwt_pkg::RAW_BITS;
	localparam int TS_W   = rwt_pkg::TS_BITS;
	localparam int CMD_W  = rwt_pkg::CMD_BITS;
	localparam int MINC_W = rwt_pkg::MINC_BITS;
	localparam int MINH_W = rwt_pkg::MINH_BITS;
	localparam int PER_W  = rwt_pkg::PER_BITS;
	localparam int RPM_W  = rwt_pkg::RPM_BITS;
	localparam int SRPM_W = rwt_pkg::SRPM_BITS;
	localparam int IDX_W  = rwt_pkg::CFG_IDX_BITS;
	localparam int DATA_W = rwt_pkg::CFG_DATA_BITS;
	localparam int S_W    = rwt_pkg::S_TDATA_BITS;
	localparam int M_W    = rwt_pkg::M_TDATA_BITS;

	// Cycles with no beat on any channel before the run is declared hung.
	localparam int IDLE_LIMIT = 2000;
	// Settle time once nothing is expected; covers the engine path with the rpm
	// divider plus the input queue and output register.
	localparam int DRAIN_CYCLES = 64;
	localparam int SAMPLE_CEIL = (1 << RAW_W) - 1;
	localparam logic [TS_W-1:0] RPM_CEIL = 64'd65535;

	// One result beat, split into its fields.
	typedef struct packed {
		logic              valid;
		logic [RPM_W-1:0]  rpm;
		logic [SRPM_W-1:0] srpm;
		logic [PER_W-1:0]  period;
		logic              level;
	} tach_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// raw_sample[9:0], timestamp_us[73:10], drive_command[81:74], zero fill
	logic [S_W-1:0] s_tdata = '0;
	// func[0]
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// speed_rpm[15:0], signed_speed_rpm[32:16], period_out_us[56:33],
	// level_is_high[57], zero fill
	logic [M_W-1:0] m_tdata;
	// speed_valid[0]
	logic [0:0] m_tuser;

	reflective_wheel_tachometer_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #1 clk = ~clk;

	// ---------------------------------------------------------------
	// Tachometer shadow: register copy and detector state, both as
	// they stand after reset.
	// ---------------------------------------------------------------
	rwt_pkg::cfg_t settings = '{rwt_pkg::RST_MIN_CONTRAST, rwt_pkg::RST_MIN_HYST,
		rwt_pkg::RST_MIN_PERIOD, rwt_pkg::RST_MAX_PERIOD, rwt_pkg::RST_TIMEOUT};
	logic [RAW_W-1:0] dark_floor = '1;       // running minimum
	logic [RAW_W-1:0] bright_peak = '0;      // running maximum
	logic comp_high = 1'b0;                  // comparator level
	logic level_armed = 1'b0;                // first comparator decision made
	logic speed_ok = 1'b0;
	logic edge_seen = 1'b0;
	logic [TS_W-1:0] last_edge_ts = '0;
	logic [PER_W-1:0] period_hold = '0;
	logic [RPM_W-1:0] rpm_hold = '0;
	logic [1:0] direction = rwt_pkg::DIR_NONE;

	tach_result_t expected_results[$];

	int beats_sent = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	int rx_hold = 0;
	int rx_draw;
	bit sender_pauses = 1'b1;
	bit receiver_pauses = 1'b1;
	logic [TS_W-1:0] wheel_ts = 64'd20_000_000;

	// Advance the shadow by one accepted beat and queue the result it owes.
	task automatic predict_tach_result(input logic kind, input logic [RAW_W-1:0] raw,
		input logic [TS_W-1:0] ts, input logic signed [CMD_W-1:0] cmd);
		int contrast, mid, hyst, lower, upper;
		logic [TS_W-1:0] period, quotient;
		logic [RPM_W-1:0] shown_rpm;
		tach_result_t res;
		if (kind == rwt_pkg::KIND_DRIVE) begin
			// zero keeps the current direction
			if (cmd != '0)
				direction = cmd[CMD_W-1] ? rwt_pkg::DIR_REV : rwt_pkg::DIR_FWD;
		end else begin
			if (raw < dark_floor)
				dark_floor = raw;
			if (raw > bright_peak)
				bright_peak = raw;
			contrast = (bright_peak >= dark_floor) ?
				int'(bright_peak) - int'(dark_floor) : 0;
			if (contrast < int'(settings.min_contrast)) begin
				// too flat to trust: comparator and edge timing stay put
				speed_ok = 1'b0;
			end else begin
				mid = int'(dark_floor) + contrast / 2;
				hyst = contrast / 8;
				if (hyst < int'(settings.min_hyst))
					hyst = int'(settings.min_hyst);
				lower = (mid > hyst) ? mid - hyst : 0;
				upper = (mid + hyst < SAMPLE_CEIL) ? mid + hyst : SAMPLE_CEIL;
				if (!level_armed) begin
					comp_high = (int'(raw) >= mid);
					level_armed = 1'b1;
				end else if (!comp_high && int'(raw) >= upper) begin
					comp_high = 1'b1;
					if (edge_seen) begin
						period = ts - last_edge_ts;
						if (period >= TS_W'(settings.min_period) &&
							period <= TS_W'(settings.max_period)) begin
							period_hold = period[PER_W-1:0];
							if (period == '0) begin
								rpm_hold = '1;
							end else begin
								quotient = TS_W'(rwt_pkg::RPM_NUMERATOR) / period;
								rpm_hold = (quotient > RPM_CEIL) ? '1 : quotient[RPM_W-1:0];
							end
							speed_ok = 1'b1;
						end
					end
					last_edge_ts = ts;
					edge_seen = 1'b1;
				end else if (comp_high && int'(raw) <= lower) begin
					comp_high = 1'b0;
				end
				if (edge_seen && (ts - last_edge_ts) > TS_W'(settings.timeout)) begin
					speed_ok = 1'b0;
					rpm_hold = '0;
				end
			end
		end
		shown_rpm = speed_ok ? rpm_hold : '0;
		res.valid = speed_ok;
		res.rpm = shown_rpm;
		case (direction)
			rwt_pkg::DIR_FWD: res.srpm = {1'b0, shown_rpm};
			rwt_pkg::DIR_REV: res.srpm = -{1'b0, shown_rpm};
			default:          res.srpm = '0;
		endcase
		res.period = period_hold;
		res.level = comp_high;
		expected_results.push_back(res);
	endtask

	// Send one input beat. Fields the block ignores for this kind carry
	// random filler. Called at a rising edge; valid stays high afterwards
	// so back-to-back beats never drop it.
	task automatic send_beat(input logic kind, input logic [RAW_W-1:0] raw,
		input logic [TS_W-1:0] ts, input logic signed [CMD_W-1:0] cmd);
		int gap;
		gap = sender_pauses ? $urandom_range(8, 0) : 0;
		if (kind == rwt_pkg::KIND_DRIVE) begin
			raw = RAW_W'($urandom);
			ts = {$urandom, $urandom};
		end else begin
			cmd = CMD_W'($urandom_range(200, 0) - 100);
		end
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= S_W'({cmd, ts, raw});
		do @(posedge clk); while (!s_tready);
		predict_tach_result(kind, raw, ts, cmd);
		beats_sent++;
	endtask

	// Stop the stream, wait for every owed result, then let the engine settle.
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all five registers, only once the block is idle.
	task automatic apply_settings(input rwt_pkg::cfg_t next);
		logic [DATA_W-1:0] value;
		wait_for_drain();
		for (int idx = int'(rwt_pkg::REG_MIN_CONTRAST); idx <= int'(rwt_pkg::REG_TIMEOUT);
			idx++) begin
			case (IDX_W'(idx))
				rwt_pkg::REG_MIN_CONTRAST: value = DATA_W'(next.min_contrast);
				rwt_pkg::REG_MIN_HYST:     value = DATA_W'(next.min_hyst);
				rwt_pkg::REG_MIN_PERIOD:   value = DATA_W'(next.min_period);
				rwt_pkg::REG_MAX_PERIOD:   value = DATA_W'(next.max_period);
				default:                   value = next.timeout;
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= IDX_W'(idx);
			cfg_data <= value;
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		settings = next;
	endtask

	// Simulated wheel: each lap is a rising edge, a few bright samples, a few
	// dark ones, with the lap length drawn around the current period window.
	// Drive commands, random noise and early spikes are mixed in.
	task automatic spin_wheel(input int beats);
		int stop_at, pick, dark_span, bright_span;
		int unsigned lo_lim, hi_lim;
		logic [TS_W-1:0] lap, noise_ts;
		stop_at = beats_sent + beats;
		lo_lim = 32'(settings.min_period);
		hi_lim = 32'(settings.max_period);
		while (beats_sent < stop_at) begin
			// stretches with and without idling on either side
			if ($urandom_range(9, 0) == 0)
				sender_pauses = ($urandom_range(3, 0) != 0);
			if ($urandom_range(9, 0) == 0)
				receiver_pauses = ($urandom_range(3, 0) != 0);

			pick = $urandom_range(99, 0);
			if (pick < 10)
				lap = TS_W'((pick < 5) ? lo_lim : hi_lim);
			else if (pick < 70 && lo_lim <= hi_lim)
				lap = TS_W'($urandom_range(hi_lim, lo_lim));
			else if (pick < 85)
				lap = (lo_lim > 0) ? TS_W'($urandom_range(lo_lim - 1, 0)) : '0;
			else
				lap = TS_W'(hi_lim + $urandom_range(2_000_000, 1));

			// exact rails half the time so the widest bands still trip
			dark_span = $urandom_range(1, 0) ? 0 : $urandom_range(200, 0);
			bright_span = $urandom_range(1, 0) ? 0 : $urandom_range(200, 0);
			for (int i = 0; i < $urandom_range(3, 1); i++)
				send_beat(rwt_pkg::KIND_SAMPLE,
					RAW_W'(SAMPLE_CEIL - $urandom_range(bright_span, 0)),
					wheel_ts + lap / 8 * TS_W'(i), '0);
			for (int i = 0; i < $urandom_range(3, 1); i++)
				send_beat(rwt_pkg::KIND_SAMPLE, RAW_W'($urandom_range(dark_span, 0)),
					wheel_ts + lap / 2 + lap / 8 * TS_W'(i), '0);
			wheel_ts += lap;

			pick = $urandom_range(99, 0);
			if (pick < 6) begin
				send_beat(rwt_pkg::KIND_DRIVE, '0, '0, CMD_W'($urandom_range(200, 0) - 100));
			end else if (pick < 14) begin
				// arbitrary reading at an arbitrary time, often far backwards
				noise_ts = {$urandom, $urandom};
				send_beat(rwt_pkg::KIND_SAMPLE, RAW_W'($urandom), noise_ts, '0);
				if ($urandom_range(1, 0))
					wheel_ts = noise_ts;
			end else if (pick < 18) begin
				// early spike three quarters into the lap
				send_beat(rwt_pkg::KIND_SAMPLE, RAW_W'(SAMPLE_CEIL), wheel_ts - lap / 4, '0);
				send_beat(rwt_pkg::KIND_SAMPLE, '0, wheel_ts - lap / 4, '0);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset settings: low contrast, first decision, first edge at time zero,
	// period limits, drive directions, timeout and wrapping timestamps.
	task automatic test_directed_defaults();
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd500, 64'd0, '0);   // spread still zero
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, 64'd0, '0);     // first decision, low
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, 64'd0, '0);  // first edge at time 0
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, 64'd10, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, 64'd1_000_000, '0); // valid, no dir
		send_beat(rwt_pkg::KIND_DRIVE, '0, '0, 8'sd0);          // keeps unknown
		send_beat(rwt_pkg::KIND_DRIVE, '0, '0, 8'sd100);
		send_beat(rwt_pkg::KIND_DRIVE, '0, '0, -8'sd100);
		send_beat(rwt_pkg::KIND_DRIVE, '0, '0, -8'sd1);
		send_beat(rwt_pkg::KIND_DRIVE, '0, '0, 8'sd1);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, 64'd1_050_000, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, 64'd1_100_000, '0); // shortest period
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, 64'd1_200_000, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, 64'd6_100_000, '0); // longest period
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, 64'd6_200_000, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, 64'd11_100_001, '0); // one past, ignored
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, 64'd11_100_010, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, 64'd11_100_060, '0); // far too short
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, 64'd17_100_061, '0);    // edge too old
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, 64'hFFFF_FFFF_FFFF_0000, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
		// next edge lands past the 64-bit wrap, one second later
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023,
			64'hFFFF_FFFF_FFFF_0000 + 64'd1_000_000, '0);
	endtask

	task automatic test_random_defaults();
		spin_wheel(240);
	endtask

	// Everything open: no contrast floor, zero hysteresis, zero period
	// allowed (saturates), widest window, largest timeout.
	task automatic test_wide_open_limits();
		apply_settings('{10'd0, 9'd0, 24'd0, 24'hFF_FFFF, 32'hFFFF_FFFF});
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, wheel_ts, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, wheel_ts, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd0, wheel_ts, '0);
		send_beat(rwt_pkg::KIND_SAMPLE, 10'd1023, wheel_ts, '0);     // zero period
		spin_wheel(240);
	endtask

	// Everything tight: full-scale contrast, widest hysteresis floor,
	// single-microsecond window, zero timeout.
	task automatic test_tight_limits();
		apply_settings('{10'd1023, 9'd511, 24'd1, 24'd1, 32'd0});
		spin_wheel(240);
	endtask

	// Minimum above maximum: no period may ever be taken.
	task automatic test_crossed_limits();
		apply_settings('{10'd500, 9'd100, 24'd3_000_000, 24'd200_000, 32'd1_000_000});
		spin_wheel(200);
	endtask

	task automatic test_random_settings();
		rwt_pkg::cfg_t next;
		wheel_ts = 64'hFFFF_FFFF_FF00_0000;   // run through the timestamp wrap
		for (int phase = 0; phase < 4; phase++) begin
			next.min_contrast = MINC_W'($urandom_range(1023, 0));
			next.min_hyst = MINH_W'($urandom_range(511, 0));
			next.min_period = PER_W'($urandom_range(1 << 21, 1));
			if ($urandom_range(3, 0) == 0)
				next.max_period = PER_W'($urandom_range(32'(next.min_period), 1));
			else
				next.max_period = PER_W'(32'(next.min_period) + $urandom_range(1 << 22, 0));
			next.timeout = $urandom_range(1, 0) ? $urandom :
				32'(next.max_period) + $urandom_range(3_000_000, 0);
			apply_settings(next);
			spin_wheel(240);
		end
	endtask

	// ---------------------------------------------------------------
	// Result side: random backpressure drawn per result beat.
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			rx_draw = receiver_pauses ? $urandom_range(8, 0) : 0;
			rx_hold <= rx_draw;
			m_tready <= (rx_draw == 0);
		end else if (rx_hold > 1) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			rx_hold <= 0;
			m_tready <= 1'b1;
		end
	end

	// Compare every result beat against the oldest owed result.
	always @(posedge clk) begin
		tach_result_t want, got;
		if (m_tvalid && m_tready) begin
			got.valid = m_tuser[0];
			got.rpm = m_tdata[15:0];
			got.srpm = m_tdata[32:16];
			got.period = m_tdata[56:33];
			got.level = m_tdata[57];
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected");
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got.valid !== want.valid) begin
					$error("speed_valid expected %0d got %0d", want.valid, got.valid);
					mismatches++;
				end
				if (got.rpm !== want.rpm) begin
					$error("speed_rpm expected %0d got %0d", want.rpm, got.rpm);
					mismatches++;
				end
				if (got.srpm !== want.srpm) begin
					$error("signed_speed_rpm expected %0d got %0d",
						$signed(want.srpm), $signed(got.srpm));
					mismatches++;
				end
				if (got.period !== want.period) begin
					$error("period_out_us expected %0d got %0d", want.period, got.period);
					mismatches++;
				end
				if (got.level !== want.level) begin
					$error("level_is_high expected %0d got %0d", want.level, got.level);
					mismatches++;
				end
			end
		end
	end

	// Hang detector: any beat on any channel restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		// driven from unknown so the asynchronous reset sees a falling edge
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_defaults();
		test_random_defaults();
		test_wide_open_limits();
		test_tight_limits();
		test_crossed_limits();
		test_random_settings();
		wait_for_drain();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
